// ===== rtl/lrpw_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and codes of the line raster pixel writer
package lrpw_pkg;

	// coordinate and derived arithmetic widths
	localparam int COORD_BITS  = 12;
	localparam int SPAN_BITS   = COORD_BITS + 1;
	localparam int ERR_BITS    = COORD_BITS + 2;
	localparam int DIM_BITS    = 12;
	localparam int PITCH_BITS  = 14;
	localparam int OFFSET_BITS = 27;
	localparam int COLOR_BITS  = 8;
	localparam int WORD_BITS   = 32;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 14;

	// packed 5:6:5 field layout
	localparam int RED_LSB   = 11;
	localparam int GREEN_LSB = 5;
	localparam int RB_BITS   = 5;
	localparam int G_BITS    = 6;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [SPAN_BITS-1:0]         span_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic [COLOR_BITS-1:0]        chan_t;

	// command codes
	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_code_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_X_OFFSET      = 3'd2,
		REG_Y_OFFSET      = 3'd3,
		REG_ROW_PITCH     = 3'd4,
		REG_WIDE_MODE     = 3'd5
	} cfg_idx_t;

	// reset values of the configuration registers
	localparam logic [DIM_BITS-1:0]   RST_SCREEN_WIDTH  = 12'd640;
	localparam logic [DIM_BITS-1:0]   RST_SCREEN_HEIGHT = 12'd480;
	localparam logic [PITCH_BITS-1:0] RST_ROW_PITCH     = 14'd2560;

	typedef struct packed {
		logic [DIM_BITS-1:0]   screen_width;
		logic [DIM_BITS-1:0]   screen_height;
		logic [DIM_BITS-1:0]   x_offset;
		logic [DIM_BITS-1:0]   y_offset;
		logic [PITCH_BITS-1:0] row_pitch;
		logic                  wide_mode;
	} cfg_t;

	// input word
	typedef struct packed {
		logic   command;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
		chan_t  red;
		chan_t  green;
		chan_t  blue;
	} cmd_t;

	// result word
	typedef struct packed {
		logic                   pixel_valid;
		coord_t                 pixel_x;
		coord_t                 pixel_y;
		logic                   visible;
		logic [OFFSET_BITS-1:0] byte_offset;
		logic [WORD_BITS-1:0]   pixel_word;
		logic                   last;
	} pix_t;

	// pixel between the stepping stage and the address stage
	typedef struct packed {
		logic   pixel_valid;
		coord_t pixel_x;
		coord_t pixel_y;
		logic   last;
		chan_t  red;
		chan_t  green;
		chan_t  blue;
	} step_t;

endpackage

// ===== rtl/lrpw_intf.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for command and pixel words
interface lrpw_cmd_if import lrpw_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lrpw_pix_if import lrpw_pkg::*; ();
	logic valid;
	logic ready;
	pix_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/lrpw_step.sv =====
`timescale 1ns / 1ps
// line setup and bresenham stepping, one pixel per accepted word
module lrpw_step import lrpw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  fire,
	input  cmd_t  item,
	output step_t pix_s1
);

	// line state, holds the most recently emitted pixel
	logic   active_q;
	coord_t major_q, end_q, minor_q;
	err_t   err_q;
	span_t  mspan_q, nspan_q;
	logic   down_q, swap_q;
	chan_t  red_q, green_q, blue_q;

	// setup signals
	logic signed [SPAN_BITS-1:0] dx, dy;
	span_t  adx, ady;
	logic   swap;
	coord_t am, an, bm, bn;
	logic   order;
	coord_t maj0, majend0, min0, min1;
	span_t  mspan0, nspan0;
	err_t   err0;
	logic   down0, last0;

	// stepping signals
	err_t   e1, e2;
	logic   carry;
	coord_t maj1, mnr1;
	logic   last1;

	// endpoint spans and axis selection
	always_comb begin
		dx     = SPAN_BITS'(item.end_x) - SPAN_BITS'(item.start_x);
		dy     = SPAN_BITS'(item.end_y) - SPAN_BITS'(item.start_y);
		adx    = dx[SPAN_BITS-1] ? span_t'(-dx) : span_t'(dx);
		ady    = dy[SPAN_BITS-1] ? span_t'(-dy) : span_t'(dy);
		swap   = ady > adx;
		am     = swap ? item.start_y : item.start_x;
		an     = swap ? item.start_x : item.start_y;
		bm     = swap ? item.end_y : item.end_x;
		bn     = swap ? item.end_x : item.end_y;
		order  = am > bm;
		maj0   = order ? bm : am;
		majend0 = order ? am : bm;
		min0   = order ? bn : an;
		min1   = order ? an : bn;
		down0  = !(min0 < min1);
		mspan0 = swap ? ady : adx;
		nspan0 = swap ? adx : ady;
		err0   = err_t'(0) - err_t'(mspan0 >> 1);
		last0  = maj0 >= majend0;
	end

	// one bresenham step from the stored pixel
	always_comb begin
		e1    = err_q + err_t'(nspan_q);
		carry = e1 > err_t'(0);
		e2    = carry ? e1 - err_t'(mspan_q) : e1;
		mnr1  = carry ? (down_q ? minor_q - coord_t'(1) : minor_q + coord_t'(1)) : minor_q;
		maj1  = major_q + coord_t'(1);
		last1 = maj1 >= end_q;
	end

	// state update on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			major_q  <= '0;
			end_q    <= '0;
			minor_q  <= '0;
			err_q    <= '0;
			mspan_q  <= '0;
			nspan_q  <= '0;
			down_q   <= 1'b0;
			swap_q   <= 1'b0;
			red_q    <= '0;
			green_q  <= '0;
			blue_q   <= '0;
		end else if (fire) begin
			if (item.command == CMD_START) begin
				active_q <= !last0;
				major_q  <= maj0;
				end_q    <= majend0;
				minor_q  <= min0;
				err_q    <= err0;
				mspan_q  <= mspan0;
				nspan_q  <= nspan0;
				down_q   <= down0;
				swap_q   <= swap;
				red_q    <= item.red;
				green_q  <= item.green;
				blue_q   <= item.blue;
			end else if (active_q) begin
				active_q <= !last1;
				major_q  <= maj1;
				minor_q  <= mnr1;
				err_q    <= e2;
			end
		end
	end

	// stage 1 pixel register
	always_ff @(posedge clk) begin
		if (fire) begin
			if (item.command == CMD_START) begin
				pix_s1.pixel_valid <= 1'b1;
				pix_s1.pixel_x     <= swap ? min0 : maj0;
				pix_s1.pixel_y     <= swap ? maj0 : min0;
				pix_s1.last        <= last0;
				pix_s1.red         <= item.red;
				pix_s1.green       <= item.green;
				pix_s1.blue        <= item.blue;
			end else if (active_q) begin
				pix_s1.pixel_valid <= 1'b1;
				pix_s1.pixel_x     <= swap_q ? mnr1 : maj1;
				pix_s1.pixel_y     <= swap_q ? maj1 : mnr1;
				pix_s1.last        <= last1;
				pix_s1.red         <= red_q;
				pix_s1.green       <= green_q;
				pix_s1.blue        <= blue_q;
			end else begin
				pix_s1 <= '0;
			end
		end
	end

endmodule

// ===== rtl/lrpw_addr.sv =====
`timescale 1ns / 1ps
// clipping, framebuffer byte offset and color packing into the output register
module lrpw_addr import lrpw_pkg::*; (
	input  logic  clk,
	input  logic  load,
	input  cfg_t  cfg,
	input  step_t pix_s1,
	output pix_t  pix_s2
);

	logic                    vis;
	logic [DIM_BITS:0]       xs, ys;
	logic [DIM_BITS+2:0]     xb;
	logic [OFFSET_BITS-1:0]  row_off, off;
	logic [WORD_BITS-1:0]    word;

	// clip test against the resolution
	always_comb begin
		vis = pix_s1.pixel_valid
			&& !pix_s1.pixel_x[COORD_BITS-1] && !pix_s1.pixel_y[COORD_BITS-1]
			&& (DIM_BITS'(pix_s1.pixel_x) < cfg.screen_width)
			&& (DIM_BITS'(pix_s1.pixel_y) < cfg.screen_height);
	end

	// byte offset: panned x times bytes per pixel plus panned y times pitch
	always_comb begin
		xs      = (DIM_BITS + 1)'(DIM_BITS'(pix_s1.pixel_x)) + (DIM_BITS + 1)'(cfg.x_offset);
		ys      = (DIM_BITS + 1)'(DIM_BITS'(pix_s1.pixel_y)) + (DIM_BITS + 1)'(cfg.y_offset);
		xb      = cfg.wide_mode ? {xs, 2'b00} : {1'b0, xs, 1'b0};
		row_off = OFFSET_BITS'(ys * cfg.row_pitch);
		off     = vis ? row_off + OFFSET_BITS'(xb) : '0;
	end

	// color word in the current pixel format
	always_comb begin
		if (cfg.wide_mode) begin
			word = {8'h00, pix_s1.red, pix_s1.green, pix_s1.blue};
		end else begin
			word = '0;
			word[RED_LSB +: RB_BITS]   = pix_s1.red[RB_BITS-1:0];
			word[GREEN_LSB +: G_BITS]  = pix_s1.green[G_BITS-1:0];
			word[0 +: RB_BITS]         = pix_s1.blue[RB_BITS-1:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			pix_s2.pixel_valid <= pix_s1.pixel_valid;
			pix_s2.pixel_x     <= pix_s1.pixel_x;
			pix_s2.pixel_y     <= pix_s1.pixel_y;
			pix_s2.visible     <= vis;
			pix_s2.byte_offset <= off;
			pix_s2.pixel_word  <= word;
			pix_s2.last        <= pix_s1.last;
		end
	end

endmodule

// ===== rtl/line_raster_pixel_writer.sv =====
`timescale 1ns / 1ps
// line raster pixel writer: bresenham line stepping with framebuffer addressing
//
// Usage: a command word on the cmd channel either starts a line (endpoints and
// color) or advances it by one pixel. Every accepted word gives exactly one word
// on the pixel channel: the pixel coordinates, a clip flag, its framebuffer byte
// offset, the packed color and a flag on the final pixel. An advance with no line
// in progress gives an all-zero word. A start drops any line in progress.
// Each accepted word passes through the stage 1 register and then the output
// register, together with its valid bit, before it reaches the pixel channel.
// Throughput: one word per cycle while pixel ready is high. The accept cycle updates
// the line state by one error add and compare; the address multiply is in stage 2.
// Stalls: when the pixel receiver holds ready low the output register keeps its
// word, stage 1 still takes one more word if it is empty, then cmd ready drops.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; unused
// indexes are ignored. The user must write them only while no line word is in flight; the block does not enforce it.
// Reset: arst_n clears the line state, empties both stages and loads the default
// 640x480, pitch 2560, 32-bit mode configuration.
module line_raster_pixel_writer import lrpw_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	lrpw_cmd_if.sink                 cmd,
	lrpw_pix_if.source               pixel
);

	cfg_t  cfg_q;
	logic  valid_s1, valid_s2;
	logic  fire, adv2;
	step_t pix_s1;
	pix_t  pix_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= RST_SCREEN_WIDTH;
			cfg_q.screen_height <= RST_SCREEN_HEIGHT;
			cfg_q.x_offset      <= '0;
			cfg_q.y_offset      <= '0;
			cfg_q.row_pitch     <= RST_ROW_PITCH;
			cfg_q.wide_mode     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[DIM_BITS-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[DIM_BITS-1:0];
				REG_X_OFFSET:      cfg_q.x_offset      <= cfg_data[DIM_BITS-1:0];
				REG_Y_OFFSET:      cfg_q.y_offset      <= cfg_data[DIM_BITS-1:0];
				REG_ROW_PITCH:     cfg_q.row_pitch     <= cfg_data[PITCH_BITS-1:0];
				REG_WIDE_MODE:     cfg_q.wide_mode     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// pipeline flow control
	assign adv2      = !valid_s2 || pixel.ready;
	assign cmd.ready = !valid_s1 || adv2;
	assign fire      = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= fire;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stepping stage
	lrpw_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (cmd.data),
		.pix_s1 (pix_s1)
	);

	// address and packing stage
	lrpw_addr u_addr (
		.clk    (clk),
		.load   (adv2 && valid_s1),
		.cfg    (cfg_q),
		.pix_s1 (pix_s1),
		.pix_s2 (pix_s2)
	);

	assign pixel.valid = valid_s2;
	assign pixel.data  = pix_s2;

	// an accepted word always reaches stage 1
	a_fire_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s1)
		else $error("accepted word lost before stage 1");

	// a stalled output keeps stage 1 from being overwritten when full
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !pixel.ready) |-> !cmd.ready)
		else $error("stage 1 overwritten during output stall");

	// clipped pixels carry no offset
	a_clip_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !pix_s2.visible) |-> (pix_s2.byte_offset == '0))
		else $error("offset given for a clipped pixel");

	// an idle advance gives an empty word
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !pix_s2.pixel_valid) |->
			(!pix_s2.visible && !pix_s2.last && pix_s2.pixel_word == '0))
		else $error("word without pixel carries data");

endmodule
